### design/assert_macros.svh
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define MCSB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("mcsb assertion failed");

// Checked on every clock edge, reset included.
`define MCSB_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("mcsb reset assertion failed");

`endif

### design/mcsb_pkg.sv
package mcsb_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int REPEAT_W = 8;
    localparam int HOLD_W   = 11;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    localparam logic [HOUR_W-1:0] HOURS_LAST = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_LAST   = 6'd59;
    localparam logic [SEC_W:0]    SEC_WRAP   = 7'd60;

    localparam logic [REPEAT_W-1:0] SLOW_REPEAT_RST   = 8'd200;
    localparam logic [REPEAT_W-1:0] MEDIUM_REPEAT_RST = 8'd66;
    localparam logic [REPEAT_W-1:0] FAST_REPEAT_RST   = 8'd22;
    localparam logic [HOLD_W-1:0]   MEDIUM_AFTER_RST  = 11'd800;
    localparam logic [HOLD_W-1:0]   FAST_AFTER_RST    = 11'd1600;

    typedef enum logic [2:0] {
        REG_SLOW_REPEAT   = 3'd0,
        REG_MEDIUM_REPEAT = 3'd1,
        REG_FAST_REPEAT   = 3'd2,
        REG_MEDIUM_AFTER  = 3'd3,
        REG_FAST_AFTER    = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        TUBE_HOUR_TENS = 2'd0,
        TUBE_HOUR_ONES = 2'd1,
        TUBE_MIN_TENS  = 2'd2,
        TUBE_MIN_ONES  = 2'd3
    } t_tube;

    typedef struct packed {
        logic [REPEAT_W-1:0] slow_repeat;
        logic [REPEAT_W-1:0] medium_repeat;
        logic [REPEAT_W-1:0] fast_repeat;
        logic [HOLD_W-1:0]   medium_after;
        logic [HOLD_W-1:0]   fast_after;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        tube_select;
        logic [3:0]        digit_value;
        logic              neon_on;
        logic [HOUR_W-1:0] hours_now;
        logic [MIN_W-1:0]  minutes_now;
    } t_result;

    // Tens digit of a value below 64.
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [6:0] tens_x10;
        logic [6:0] diff;
        tens_x10 = 7'(tens_of(v)) * 7'd10;
        diff = 7'(v) - tens_x10;
        return diff[3:0];
    endfunction

endpackage

### design/mcsb_ifs.sv
interface mcsb_in_if;
    logic valid;
    logic ready;
    logic hour_button;
    logic minute_button;
    logic second_clock_level;

    modport source (output valid, hour_button, minute_button, second_clock_level,
                    input ready);
    modport sink (input valid, hour_button, minute_button, second_clock_level,
                  output ready);
endinterface

interface mcsb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] tube_select;
    logic [3:0] digit_value;
    logic       neon_on;
    logic [4:0] hours_now;
    logic [5:0] minutes_now;

    modport source (output valid, tube_select, digit_value, neon_on, hours_now,
                    minutes_now, input ready);
    modport sink (input valid, tube_select, digit_value, neon_on, hours_now,
                  minutes_now, output ready);
endinterface

### design/mcsb_apb_regs.sv
module mcsb_apb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mcsb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mcsb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mcsb_pkg::APB_DATA_W-1:0]  prdata,
    output mcsb_pkg::t_cfg                   o_cfg
);

    mcsb_pkg::t_cfg   r_cfg;
    mcsb_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx = mcsb_pkg::t_reg_idx'(paddr[mcsb_pkg::APB_ADDR_W-1:2]);
    assign w_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_repeat   <= mcsb_pkg::SLOW_REPEAT_RST;
            r_cfg.medium_repeat <= mcsb_pkg::MEDIUM_REPEAT_RST;
            r_cfg.fast_repeat   <= mcsb_pkg::FAST_REPEAT_RST;
            r_cfg.medium_after  <= mcsb_pkg::MEDIUM_AFTER_RST;
            r_cfg.fast_after    <= mcsb_pkg::FAST_AFTER_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                mcsb_pkg::REG_SLOW_REPEAT:
                    r_cfg.slow_repeat <= pwdata[mcsb_pkg::REPEAT_W-1:0];
                mcsb_pkg::REG_MEDIUM_REPEAT:
                    r_cfg.medium_repeat <= pwdata[mcsb_pkg::REPEAT_W-1:0];
                mcsb_pkg::REG_FAST_REPEAT:
                    r_cfg.fast_repeat <= pwdata[mcsb_pkg::REPEAT_W-1:0];
                mcsb_pkg::REG_MEDIUM_AFTER:
                    r_cfg.medium_after <= pwdata[mcsb_pkg::HOLD_W-1:0];
                mcsb_pkg::REG_FAST_AFTER:
                    r_cfg.fast_after <= pwdata[mcsb_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            mcsb_pkg::REG_SLOW_REPEAT:
                prdata = mcsb_pkg::APB_DATA_W'(r_cfg.slow_repeat);
            mcsb_pkg::REG_MEDIUM_REPEAT:
                prdata = mcsb_pkg::APB_DATA_W'(r_cfg.medium_repeat);
            mcsb_pkg::REG_FAST_REPEAT:
                prdata = mcsb_pkg::APB_DATA_W'(r_cfg.fast_repeat);
            mcsb_pkg::REG_MEDIUM_AFTER:
                prdata = mcsb_pkg::APB_DATA_W'(r_cfg.medium_after);
            mcsb_pkg::REG_FAST_AFTER:
                prdata = mcsb_pkg::APB_DATA_W'(r_cfg.fast_after);
            default: prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### design/mcsb_button.sv
module mcsb_button (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_pressed,
    input  mcsb_pkg::t_cfg i_cfg,
    output logic           o_step
);

    logic [mcsb_pkg::REPEAT_W-1:0] r_repeat, n_repeat;
    logic [mcsb_pkg::HOLD_W-1:0]   r_hold, n_hold;
    logic [mcsb_pkg::HOLD_W-1:0]   w_hold_inc;
    logic [mcsb_pkg::REPEAT_W-1:0] w_period;

    always_comb begin
        w_hold_inc = (r_hold == mcsb_pkg::HOLD_MAX) ? r_hold : r_hold + 1'b1;

        // Fast rate only once both thresholds are met.
        w_period = i_cfg.slow_repeat;
        if (w_hold_inc >= i_cfg.medium_after) begin
            w_period = i_cfg.medium_repeat;
            if (w_hold_inc >= i_cfg.fast_after)
                w_period = i_cfg.fast_repeat;
        end

        o_step = i_pressed && (r_repeat >= w_period);

        if (!i_pressed) begin
            n_hold   = '0;
            n_repeat = '0;
        end else begin
            n_hold   = w_hold_inc;
            n_repeat = o_step ? '0 : r_repeat + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat <= '0;
            r_hold   <= '0;
        end else if (i_en) begin
            r_repeat <= n_repeat;
            r_hold   <= n_hold;
        end
    end

endmodule

### design/mcsb_time.sv
module mcsb_time (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_hour_step,
    input  logic              i_min_step,
    input  logic              i_level,
    output mcsb_pkg::t_result o_res
);

    logic [mcsb_pkg::HOUR_W-1:0] r_hour, n_hour;
    logic [mcsb_pkg::MIN_W-1:0]  r_min, n_min;
    logic [mcsb_pkg::SEC_W-1:0]  r_sec, n_sec;
    logic [1:0]                  r_tube;
    logic                        r_prev_level;

    logic [mcsb_pkg::HOUR_W-1:0] w_hour_btn;
    logic [mcsb_pkg::MIN_W-1:0]  w_min_btn;
    logic [mcsb_pkg::SEC_W:0]    w_sec_sum;
    logic [3:0]                  w_digit;

    always_comb begin
        case (mcsb_pkg::t_tube'(r_tube))
            mcsb_pkg::TUBE_HOUR_TENS: w_digit = mcsb_pkg::tens_of(6'(r_hour));
            mcsb_pkg::TUBE_HOUR_ONES: w_digit = mcsb_pkg::ones_of(6'(r_hour));
            mcsb_pkg::TUBE_MIN_TENS:  w_digit = mcsb_pkg::tens_of(r_min);
            default:                  w_digit = mcsb_pkg::ones_of(r_min);
        endcase

        w_hour_btn = r_hour;
        if (i_hour_step)
            w_hour_btn = (r_hour >= mcsb_pkg::HOURS_LAST) ? '0 : r_hour + 1'b1;
        // Button stepping of minutes never carries into hours.
        w_min_btn = r_min;
        if (i_min_step)
            w_min_btn = (r_min >= mcsb_pkg::MIN_LAST) ? '0 : r_min + 1'b1;

        w_sec_sum = (i_hour_step || i_min_step) ? '0 : {1'b0, r_sec};
        w_sec_sum = w_sec_sum + {6'd0, (!i_level && r_prev_level)};

        n_hour = w_hour_btn;
        n_min  = w_min_btn;
        n_sec  = w_sec_sum[mcsb_pkg::SEC_W-1:0];
        if (w_sec_sum >= mcsb_pkg::SEC_WRAP) begin
            n_sec = '0;
            if (w_min_btn >= mcsb_pkg::MIN_LAST) begin
                n_min  = '0;
                n_hour = (w_hour_btn >= mcsb_pkg::HOURS_LAST) ? '0 : w_hour_btn + 1'b1;
            end else begin
                n_min = w_min_btn + 1'b1;
            end
        end

        o_res.tube_select = r_tube;
        o_res.digit_value = w_digit;
        o_res.neon_on     = i_level;
        o_res.hours_now   = n_hour;
        o_res.minutes_now = n_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour       <= '0;
            r_min        <= '0;
            r_sec        <= '0;
            r_tube       <= '0;
            r_prev_level <= 1'b0;
        end else if (i_en) begin
            r_hour       <= n_hour;
            r_min        <= n_min;
            r_sec        <= n_sec;
            r_tube       <= r_tube + 1'b1;
            r_prev_level <= i_level;
        end
    end

endmodule

### design/multiplexed_clock_with_set_buttons.sv
// A tick accepted into the input register moves into the result register once the output
// is free. Throughput: one tick per cycle while unstalled; each of the input and result
// registers holds one request, so an empty input register takes a tick while a result waits.
// Reset (i_rst_n low, synchronous): time, tube index, button counters and both stage
// valids clear; configuration returns to its default values.
`include "assert_macros.svh"

module multiplexed_clock_with_set_buttons (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mcsb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mcsb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mcsb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    mcsb_in_if.sink                          i_item,
    mcsb_out_if.source                       o_result
);

    mcsb_pkg::t_cfg    w_cfg;
    mcsb_pkg::t_result w_res;
    mcsb_pkg::t_result r_res;

    logic r_in_valid;
    logic r_hb, r_mb, r_lvl;
    logic r_out_valid;
    logic w_advance;
    logic w_in_ready;
    logic w_hour_step, w_min_step;

    assign pready = 1'b1;

    mcsb_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign w_in_ready = !r_in_valid || w_advance;
    assign i_item.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_item.valid) begin
            r_hb  <= i_item.hour_button;
            r_mb  <= i_item.minute_button;
            r_lvl <= i_item.second_clock_level;
        end
    end

    mcsb_button u_hour_btn (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_advance),
        .i_pressed (r_hb),
        .i_cfg     (w_cfg),
        .o_step    (w_hour_step)
    );

    mcsb_button u_min_btn (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_advance),
        .i_pressed (r_mb),
        .i_cfg     (w_cfg),
        .o_step    (w_min_step)
    );

    mcsb_time u_time (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_advance),
        .i_hour_step (w_hour_step),
        .i_min_step  (w_min_step),
        .i_level     (r_lvl),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance)
            r_res <= w_res;
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.tube_select = r_res.tube_select;
    assign o_result.digit_value = r_res.digit_value;
    assign o_result.neon_on     = r_res.neon_on;
    assign o_result.hours_now   = r_res.hours_now;
    assign o_result.minutes_now = r_res.minutes_now;

    `MCSB_ASSERT(a_advance_fills_out, w_advance |=> r_out_valid)
    `MCSB_ASSERT(a_tube_steps, w_advance |=> (o_result.tube_select == 2'($past(w_res.tube_select))))
    `MCSB_ASSERT(a_empty_stage_ready, !r_in_valid |-> i_item.ready)
    `MCSB_ASSERT(a_hours_range, r_out_valid |-> (r_res.hours_now <= mcsb_pkg::HOURS_LAST))
    `MCSB_ASSERT_RST(a_reset_clears, !i_rst_n |=> (!r_out_valid && !r_in_valid))

endmodule
